[sv/frt_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, types and helper function of the fan tachometer rpm meter.
package frt_pkg;

   localparam int W_TIME     = 32;
   localparam int W_SPEED    = 16;
   localparam int W_PPR      = 8;
   localparam int W_WEIGHT   = 11;
   localparam int TIME_SHIFT = 5;
   localparam int W_SINCE    = W_TIME - TIME_SHIFT;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // divider: dividend and quotient stay below 2^26 (at most 1000000 * 60)
   localparam int DIV_W     = 26;
   localparam int DIV_CNT_W = 5;

   // filter accumulator: 65535 * 1024 fits in 27 bits
   localparam int ACC_W       = 27;
   localparam int MAC_CNT_W   = 4;
   localparam int FILTER_BITS = 10;

   localparam logic [DIV_W-1:0]    TICKS_PER_SEC = DIV_W'(1000000);
   localparam logic [W_WEIGHT-1:0] FILTER_ONE    = W_WEIGHT'(1024);

   localparam logic [W_SPEED-1:0] RST_MIN_SPEED = W_SPEED'(300);
   localparam logic [W_SPEED-1:0] RST_MAX_SPEED = W_SPEED'(3000);
   localparam logic [W_PPR-1:0]   RST_PPR       = W_PPR'(2);
   localparam logic [W_WEIGHT-1:0] RST_WEIGHT   = W_WEIGHT'(512);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MIN_SPEED,
      CSR_MAX_SPEED,
      CSR_PPR,
      CSR_WEIGHT
   } csr_reg_type;

   typedef enum logic {
      FUNC_EDGE    = 1'b0,
      FUNC_MEASURE = 1'b1
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LIMIT_DIV,
      ST_LIMIT_PPR,
      ST_RATE_DIV,
      ST_RATE_PPR,
      ST_FILTER,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              start;
      logic [DIV_W-1:0]  dividend;
      logic [W_TIME-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic                start;
      logic [W_SPEED-1:0]  prev;
      logic [W_SPEED-1:0]  raw;
      logic [W_WEIGHT-1:0] weight;
   } mac_req_type;

   // q * 60 as (q << 6) - (q << 2)
   function automatic logic [DIV_W-1:0] times_60(input logic [DIV_W-1:0] q);
      logic [DIV_W-1:0] a;
      logic [DIV_W-1:0] b;
      a = {q[DIV_W-7:0], 6'b0};
      b = {q[DIV_W-3:0], 2'b0};
      return a - b;
   endfunction

endpackage

[sv/frt_if.sv]
`timescale 1ns / 1ps
// Handshake interfaces for the request, response and register write channels.
interface frt_req_if;
   import frt_pkg::*;
   logic              valid;
   logic              ready;
   logic              func;
   logic [W_TIME-1:0] timestamp;
   modport source (output valid, func, timestamp, input ready);
   modport sink (input valid, func, timestamp, output ready);
   modport monitor (input valid, ready, func, timestamp);
endinterface

interface frt_rsp_if;
   import frt_pkg::*;
   logic               valid;
   logic               ready;
   logic [W_SPEED-1:0] speed_rpm;
   logic               stalled;
   modport source (output valid, speed_rpm, stalled, input ready);
   modport sink (input valid, speed_rpm, stalled, output ready);
   modport monitor (input valid, ready, speed_rpm, stalled);
endinterface

interface frt_csr_if;
   import frt_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
   modport monitor (input valid, ready, index, data);
endinterface

[sv/frt_div.sv]
`timescale 1ns / 1ps
// Radix-2 restoring divider, one quotient bit per cycle.
module frt_div (
   input  logic                       clock,
   input  logic                       reset,
   input  frt_pkg::div_req_type       div_req,
   output logic                       done,
   output logic [frt_pkg::DIV_W-1:0]  quotient
);
   import frt_pkg::*;

   logic [DIV_W-1:0]     rem_ff, rem_in;
   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [W_TIME-1:0]    den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [DIV_W:0]    trial;
   logic [W_TIME-1:0] trial_ext;
   logic [W_TIME-1:0] diff;
   logic              ge;

   always_comb begin
      trial     = {rem_ff, quo_ff[DIV_W-1]};
      trial_ext = W_TIME'(trial);
      ge        = trial_ext >= den_ff;
      diff      = trial_ext - den_ff;

      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         den_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract when it fits
         rem_in = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[sv/frt_mac.sv]
`timescale 1ns / 1ps
// Bit-serial weighted average: (prev * k + raw * (1024 - k)) >> 10.
module frt_mac (
   input  logic                         clock,
   input  logic                         reset,
   input  frt_pkg::mac_req_type         mac_req,
   output logic                         done,
   output logic [frt_pkg::W_SPEED-1:0]  result
);
   import frt_pkg::*;

   logic [ACC_W-1:0]     acc_ff, acc_in;
   logic [ACC_W-1:0]     prev_ff, prev_in;
   logic [ACC_W-1:0]     raw_ff, raw_in;
   logic [W_WEIGHT-1:0]  k_ff, k_in;
   logic [W_WEIGHT-1:0]  kc_ff, kc_in;
   logic [MAC_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   always_comb begin
      acc_in  = acc_ff;
      prev_in = prev_ff;
      raw_in  = raw_ff;
      k_in    = k_ff;
      kc_in   = kc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mac_req.start) begin
         acc_in  = '0;
         prev_in = ACC_W'(mac_req.prev);
         raw_in  = ACC_W'(mac_req.raw);
         k_in    = mac_req.weight;
         kc_in   = FILTER_ONE - mac_req.weight;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // add the partial products of one weight bit, advance
         acc_in  = acc_ff + (k_ff[0] ? prev_ff : '0) + (kc_ff[0] ? raw_ff : '0);
         prev_in = {prev_ff[ACC_W-2:0], 1'b0};
         raw_in  = {raw_ff[ACC_W-2:0], 1'b0};
         k_in    = {1'b0, k_ff[W_WEIGHT-1:1]};
         kc_in   = {1'b0, kc_ff[W_WEIGHT-1:1]};
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == MAC_CNT_W'(W_WEIGHT - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      acc_ff  <= acc_in;
      prev_ff <= prev_in;
      raw_ff  <= raw_in;
      k_ff    <= k_in;
      kc_ff   <= kc_in;
   end

   assign done   = done_ff;
   assign result = acc_ff[FILTER_BITS +: W_SPEED];

endmodule

[sv/fan_tach_rpm_meter.sv]
`timescale 1ns / 1ps
// Top level of the fan tachometer rpm meter: registers, sequencer and result register.
//
//   channel   direction  payload                       handshake
//   req_bus   in         func, timestamp               valid / ready
//   rsp_bus   out        speed_rpm, stalled            valid / ready
//   csr_bus   in         index, data (register write)  valid / ready, ready tied high
//
// An edge item is taken in the idle state and gives no result.
// A measure item runs up to four serial divisions on the shared radix-2 divider and
// then the serial filter; when the fan is found stalled, only the two limit divisions
// run before the filter.
// Reset is synchronous and restores the register defaults and the speed state.
// A result waits in the output register; edge items are still taken meanwhile,
// and a finished measure holds in its last step until the register frees up.
module fan_tach_rpm_meter (
   input logic   clock,
   input logic   reset,
   frt_req_if.sink   req_bus,
   frt_rsp_if.source rsp_bus,
   frt_csr_if.sink   csr_bus
);
   import frt_pkg::*;

   // configuration registers
   logic [W_SPEED-1:0]  min_speed_ff, min_speed_in;
   logic [W_SPEED-1:0]  max_speed_ff, max_speed_in;
   logic [W_PPR-1:0]    ppr_ff, ppr_in;
   logic [W_WEIGHT-1:0] weight_ff, weight_in;

   // speed state
   logic [W_TIME-1:0]  last_edge_ff, last_edge_in;
   logic [W_TIME-1:0]  period_ff, period_in;
   logic [W_SPEED-1:0] filtered_ff, filtered_in;

   // per-measure working registers
   logic [W_SINCE-1:0] since_ff, since_in;
   logic               stall_ff, stall_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [W_SPEED-1:0] rsp_speed_ff, rsp_speed_in;
   logic               rsp_stall_ff, rsp_stall_in;

   state_type state_ff, state_in;

   div_req_type        div_req;
   logic               div_done;
   logic [DIV_W-1:0]   div_q;
   mac_req_type        mac_req;
   logic               mac_done;
   logic [W_SPEED-1:0] mac_result;

   logic [W_SPEED-1:0]  min_eff;
   logic [W_PPR-1:0]    ppr_eff;
   logic [W_WEIGHT-1:0] weight_eff;
   logic [W_TIME-1:0]   period_eff;
   logic [W_TIME-1:0]   elapsed;
   logic                req_fire;
   logic                rsp_free;
   logic                stall_now;
   logic [W_SPEED-1:0]  raw_clamped;

   frt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .done     (div_done),
      .quotient (div_q)
   );

   frt_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .mac_req (mac_req),
      .done    (mac_done),
      .result  (mac_result)
   );

   // zero divisors count as one, the weight saturates at full scale
   assign min_eff    = (min_speed_ff == '0) ? W_SPEED'(1) : min_speed_ff;
   assign ppr_eff    = (ppr_ff == '0) ? W_PPR'(1) : ppr_ff;
   assign weight_eff = (weight_ff > FILTER_ONE) ? FILTER_ONE : weight_ff;
   assign period_eff = (period_ff == '0) ? W_TIME'(1) : period_ff;

   assign elapsed  = req_bus.timestamp - last_edge_ff;
   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   // stall when either the last period or the time since the last edge hits the limit
   assign stall_now = (period_ff >= W_TIME'(div_q)) ||
                      (W_TIME'(since_ff) >= W_TIME'(div_q));
   assign raw_clamped = (div_q > DIV_W'(max_speed_ff)) ? max_speed_ff : div_q[W_SPEED-1:0];

   // register writes
   always_comb begin
      min_speed_in = min_speed_ff;
      max_speed_in = max_speed_ff;
      ppr_in       = ppr_ff;
      weight_in    = weight_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_MIN_SPEED: min_speed_in = csr_bus.data[W_SPEED-1:0];
            CSR_MAX_SPEED: max_speed_in = csr_bus.data[W_SPEED-1:0];
            CSR_PPR:       ppr_in       = csr_bus.data[W_PPR-1:0];
            CSR_WEIGHT:    weight_in    = csr_bus.data[W_WEIGHT-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      last_edge_in = last_edge_ff;
      period_in    = period_ff;
      filtered_in  = filtered_ff;
      since_in     = since_ff;
      stall_in     = stall_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rsp_speed_in = rsp_speed_ff;
      rsp_stall_in = rsp_stall_ff;

      div_req.start    = 1'b0;
      div_req.dividend = TICKS_PER_SEC;
      div_req.divisor  = W_TIME'(ppr_eff);
      mac_req.start    = 1'b0;
      mac_req.prev     = filtered_ff;
      mac_req.raw      = raw_clamped;
      mac_req.weight   = weight_eff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.func == FUNC_EDGE) begin
                  // record the scaled half-period and the edge time
                  period_in    = W_TIME'(elapsed[W_TIME-1:TIME_SHIFT]);
                  last_edge_in = req_bus.timestamp;
               end else begin
                  // limit: 1000000 / min_speed first
                  since_in        = elapsed[W_TIME-1:TIME_SHIFT];
                  div_req.start   = 1'b1;
                  div_req.divisor = W_TIME'(min_eff);
                  state_in        = ST_LIMIT_DIV;
               end
            end
         end
         ST_LIMIT_DIV: begin
            if (div_done) begin
               div_req.start    = 1'b1;
               div_req.dividend = times_60(div_q);
               state_in         = ST_LIMIT_PPR;
            end
         end
         ST_LIMIT_PPR: begin
            if (div_done) begin
               stall_in = stall_now;
               if (stall_now) begin
                  // raw speed forced to zero, go straight to the filter
                  mac_req.start = 1'b1;
                  mac_req.raw   = '0;
                  state_in      = ST_FILTER;
               end else begin
                  div_req.start   = 1'b1;
                  div_req.divisor = period_eff;
                  state_in        = ST_RATE_DIV;
               end
            end
         end
         ST_RATE_DIV: begin
            if (div_done) begin
               div_req.start    = 1'b1;
               div_req.dividend = times_60(div_q);
               state_in         = ST_RATE_PPR;
            end
         end
         ST_RATE_PPR: begin
            if (div_done) begin
               mac_req.start = 1'b1;
               state_in      = ST_FILTER;
            end
         end
         ST_FILTER: begin
            if (mac_done) begin
               filtered_in = mac_result;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the result register is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_speed_in = filtered_ff;
               rsp_stall_in = stall_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         min_speed_ff <= RST_MIN_SPEED;
         max_speed_ff <= RST_MAX_SPEED;
         ppr_ff       <= RST_PPR;
         weight_ff    <= RST_WEIGHT;
         last_edge_ff <= '0;
         period_ff    <= W_TIME'(1);
         filtered_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         min_speed_ff <= min_speed_in;
         max_speed_ff <= max_speed_in;
         ppr_ff       <= ppr_in;
         weight_ff    <= weight_in;
         last_edge_ff <= last_edge_in;
         period_ff    <= period_in;
         filtered_ff  <= filtered_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      since_ff     <= since_in;
      stall_ff     <= stall_in;
      rsp_speed_ff <= rsp_speed_in;
      rsp_stall_ff <= rsp_stall_in;
   end

   assign req_bus.ready     = (state_ff == ST_IDLE);
   assign csr_bus.ready     = 1'b1;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.speed_rpm = rsp_speed_ff;
   assign rsp_bus.stalled   = rsp_stall_ff;

endmodule

[sv/frt_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the fan tachometer rpm meter, bound to the top level.
module frt_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        req_func,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [frt_pkg::W_SPEED-1:0] rsp_speed_rpm,
   input logic                        rsp_stalled
);
   import frt_pkg::*;

   // a waiting result holds its payload until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_speed_rpm) && $stable(rsp_stalled)))
      else $error("response dropped or changed while stalled");

   // a measure item keeps the block busy for at least the next cycle
   a_measure_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func == FUNC_MEASURE) |=> !req_ready)
      else $error("request taken right after a measure item");

   // no result appears in the cycle right after an accepted item
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("response raised directly after an accepted item");

   // reset empties the result register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind fan_tach_rpm_meter frt_checker u_frt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_bus.valid),
   .req_ready     (req_bus.ready),
   .req_func      (req_bus.func),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_speed_rpm (rsp_bus.speed_rpm),
   .rsp_stalled   (rsp_bus.stalled)
);
